@@ hdl/sfrc_pkg.sv @@
// Package with the shared constants and codes of the sensor frame receive checker.
`timescale 1ns / 1ps
package sfrc_pkg;

	// Frame layout.
	localparam int unsigned HEADER_BYTES   = 9;
	localparam int unsigned CHECKSUM_BYTES = 2;
	localparam int unsigned START_LAST_POS = 1;
	localparam int unsigned ADDR_LAST_POS  = 5;
	localparam int unsigned ID_POS         = 6;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_START_CODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODULE_ADDRESS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ID_COMMAND     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ID_DATA        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ID_ACK         = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ID_END_DATA    = 3'd5;

	localparam logic [15:0] START_CODE_RST     = 16'hEF01;
	localparam logic [31:0] MODULE_ADDRESS_RST = 32'hFFFF_FFFF;
	localparam logic [7:0]  ID_COMMAND_RST     = 8'd1;
	localparam logic [7:0]  ID_DATA_RST        = 8'd2;
	localparam logic [7:0]  ID_ACK_RST         = 8'd7;
	localparam logic [7:0]  ID_END_DATA_RST    = 8'd8;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Frame status codes.
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_SHORT    = 3'd1;
	localparam logic [2:0] STAT_CHECKSUM = 3'd2;
	localparam logic [2:0] STAT_START    = 3'd3;
	localparam logic [2:0] STAT_ADDRESS  = 3'd4;
	localparam logic [2:0] STAT_ID       = 3'd5;
	localparam logic [2:0] STAT_EXTRA    = 3'd6;

	// Header fault flag bits.
	localparam int unsigned FLT_START   = 0;
	localparam int unsigned FLT_ADDRESS = 1;
	localparam int unsigned FLT_ID      = 2;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] payload_value;
		logic [8:0] payload_index;
		logic [2:0] frame_status;
		logic [7:0] packet_id;
		logic [15:0] length_field;
	} sfrc_result_t;

endpackage

@@ hdl/sfrc_ifs.sv @@
// Valid/ready channel interfaces for received bytes and for results.
`timescale 1ns / 1ps
interface sfrc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_bytes;

	modport source (output valid, output rx_byte, output end_of_bytes, input ready);
	modport sink (input valid, input rx_byte, input end_of_bytes, output ready);
endinterface

interface sfrc_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_value;
	logic [8:0]  payload_index;
	logic [2:0]  frame_status;
	logic [7:0]  packet_id;
	logic [15:0] length_field;

	modport source (output valid, output result_kind, output payload_value,
		output payload_index, output frame_status, output packet_id,
		output length_field, input ready);
	modport sink (input valid, input result_kind, input payload_value,
		input payload_index, input frame_status, input packet_id,
		input length_field, output ready);
endinterface

@@ hdl/sensor_frame_receive_checker_unit.sv @@
// Top level of the sensor frame receive checker: byte parser, checksum and status logic.
`timescale 1ns / 1ps
// The block takes the bytes of one module reply frame, one transaction per byte, and
// accepts a new byte in every cycle while results are being taken. A frame consists of
// a two-byte start code, a four-byte module address, a packet id, a big-endian 16-bit
// length, length minus two payload bytes and a big-endian 16-bit additive checksum over
// the id, length and payload bytes. Every payload byte leaves as a payload result as
// soon as it is parsed; the byte marked with end_of_bytes leaves one frame status result
// instead and resets the parser for the next frame. Bytes that are neither payload nor
// last produce no result. A byte is registered in the input stage at acceptance, and
// its result is registered in the result register when the byte moves on; the sustained
// rate is one byte per cycle while results are being taken. A full result register that
// is not taken holds the input stage, and the input stage takes a new byte whenever it
// is empty or moving on. Frames longer than MAX_FRAME_BYTES bytes stop updating the
// parser and end with the extra bytes status. Configuration registers are written through
// a plain write port and may only change while no frame is in progress.
module sensor_frame_receive_checker_unit #(
	parameter int unsigned MAX_FRAME_BYTES = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [sfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sfrc_pkg::CFG_DATA_W-1:0]  cfg_data,
	sfrc_rx_if.sink                         rx,
	sfrc_res_if.source                      result
);
	import sfrc_pkg::*;

	// The byte counter must be able to hold MAX_FRAME_BYTES itself, where it saturates.
	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

	// Configuration registers.
	logic [15:0] start_code_q;
	logic [31:0] module_address_q;
	logic [7:0]  id_command_q;
	logic [7:0]  id_data_q;
	logic [7:0]  id_ack_q;
	logic [7:0]  id_end_data_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state.
	logic [POS_W-1:0] byte_pos_q;
	logic [15:0]      sum_q;
	logic [15:0]      len_q;
	logic [7:0]       id_q;
	logic [7:0]       check_hi_q;
	logic [2:0]       flags_q;
	logic [31:0]      shift_q;

	// Result register.
	logic         res_valid_q;
	sfrc_result_t res_q;

	// Next-state and result logic.
	logic             out_free;
	logic             advance;
	logic             overflow;
	logic [POS_W-1:0] pos_n;
	logic [15:0]      sum_n;
	logic [15:0]      len_n;
	logic [7:0]       id_n;
	logic [7:0]       check_hi_n;
	logic [2:0]       flags_n;
	logic [31:0]      shift_n;
	logic [15:0]      pay_cnt_cur;
	logic [15:0]      pay_cnt_n;
	logic [POS_W-1:0] pay_pos;
	logic             emit_payload;
	logic [17:0]      need_bytes;
	logic [2:0]       status_n;
	logic             has_result;
	sfrc_result_t     res_n;

	// The result register can load when it is empty or being drained this cycle.
	assign out_free  = !res_valid_q || result.ready;
	assign advance   = valid_s1 && out_free;
	assign rx.ready  = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q     <= START_CODE_RST;
			module_address_q <= MODULE_ADDRESS_RST;
			id_command_q     <= ID_COMMAND_RST;
			id_data_q        <= ID_DATA_RST;
			id_ack_q         <= ID_ACK_RST;
			id_end_data_q    <= ID_END_DATA_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_START_CODE:     start_code_q     <= cfg_data[15:0];
				REG_MODULE_ADDRESS: module_address_q <= cfg_data[31:0];
				REG_ID_COMMAND:     id_command_q     <= cfg_data[7:0];
				REG_ID_DATA:        id_data_q        <= cfg_data[7:0];
				REG_ID_ACK:         id_ack_q         <= cfg_data[7:0];
				REG_ID_END_DATA:    id_end_data_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: the byte sits here while the parser state decides on it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.end_of_bytes;
		end
	end

	// Parser: below MAX_FRAME_BYTES, one byte moves the frame position by one and updates
	// whichever header field, sum or checksum byte that position names.
	always_comb begin
		overflow     = (byte_pos_q >= POS_W'(MAX_FRAME_BYTES));
		pos_n        = byte_pos_q;
		sum_n        = sum_q;
		len_n        = len_q;
		id_n         = id_q;
		check_hi_n   = check_hi_q;
		flags_n      = flags_q;
		shift_n      = shift_q;
		emit_payload = 1'b0;
		pay_cnt_cur  = (len_q >= 16'(CHECKSUM_BYTES)) ? len_q - 16'(CHECKSUM_BYTES) : 16'd0;
		pay_pos      = byte_pos_q - POS_W'(HEADER_BYTES);

		if (!overflow) begin
			pos_n = byte_pos_q + POS_W'(1);
			if (byte_pos_q < POS_W'(ID_POS)) begin
				// Start code and address bytes, most significant first.
				shift_n = {shift_q[23:0], byte_s1};
				if (byte_pos_q == POS_W'(START_LAST_POS) && shift_n[15:0] != start_code_q) begin
					flags_n[FLT_START] = 1'b1;
				end
				if (byte_pos_q == POS_W'(ADDR_LAST_POS) && shift_n != module_address_q) begin
					flags_n[FLT_ADDRESS] = 1'b1;
				end
			end else if (byte_pos_q == POS_W'(ID_POS)) begin
				id_n  = byte_s1;
				sum_n = sum_q + 16'(byte_s1);
				if (byte_s1 != id_command_q && byte_s1 != id_data_q &&
					byte_s1 != id_ack_q && byte_s1 != id_end_data_q) begin
					flags_n[FLT_ID] = 1'b1;
				end
			end else if (byte_pos_q < POS_W'(HEADER_BYTES)) begin
				len_n = {len_q[7:0], byte_s1};
				sum_n = sum_q + 16'(byte_s1);
			end else begin
				if (17'(pay_pos) < 17'(pay_cnt_cur)) begin
					sum_n        = sum_q + 16'(byte_s1);
					emit_payload = 1'b1;
				end else if (17'(pay_pos) == 17'(pay_cnt_cur)) begin
					check_hi_n = byte_s1;
				end else if (17'(pay_pos) == 17'(pay_cnt_cur) + 17'd1) begin
					// A matching checksum leaves the sum at zero.
					sum_n = sum_q ^ {check_hi_q, byte_s1};
				end
			end
		end

		// Frame status, judged on the state after this byte, first match wins.
		pay_cnt_n  = (len_n >= 16'(CHECKSUM_BYTES)) ? len_n - 16'(CHECKSUM_BYTES) : 16'd0;
		need_bytes = 18'(HEADER_BYTES) + 18'(pay_cnt_n) + 18'(CHECKSUM_BYTES);
		if (overflow) begin
			status_n = STAT_EXTRA;
		end else if (pos_n < POS_W'(HEADER_BYTES) || 18'(pos_n) < need_bytes) begin
			status_n = STAT_SHORT;
		end else if (sum_n != 16'd0) begin
			status_n = STAT_CHECKSUM;
		end else if (flags_n[FLT_START]) begin
			status_n = STAT_START;
		end else if (flags_n[FLT_ADDRESS]) begin
			status_n = STAT_ADDRESS;
		end else if (flags_n[FLT_ID]) begin
			status_n = STAT_ID;
		end else if (17'(pos_n) != 17'(HEADER_BYTES) + 17'(len_n)) begin
			status_n = STAT_EXTRA;
		end else begin
			status_n = STAT_OK;
		end

		// The status result takes the place of a payload result on the last byte.
		has_result          = last_s1 || emit_payload;
		res_n.packet_id     = id_n;
		res_n.length_field  = len_n;
		if (last_s1) begin
			res_n.result_kind   = KIND_STATUS;
			res_n.payload_value = 8'd0;
			res_n.payload_index = 9'd0;
			res_n.frame_status  = status_n;
		end else begin
			res_n.result_kind   = KIND_PAYLOAD;
			res_n.payload_value = byte_s1;
			res_n.payload_index = 9'(pay_pos);
			res_n.frame_status  = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			sum_q      <= '0;
			len_q      <= '0;
			id_q       <= '0;
			check_hi_q <= '0;
			flags_q    <= '0;
			shift_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				byte_pos_q <= '0;
				sum_q      <= '0;
				len_q      <= '0;
				id_q       <= '0;
				check_hi_q <= '0;
				flags_q    <= '0;
				shift_q    <= '0;
			end else begin
				byte_pos_q <= pos_n;
				sum_q      <= sum_n;
				len_q      <= len_n;
				id_q       <= id_n;
				check_hi_q <= check_hi_n;
				flags_q    <= flags_n;
				shift_q    <= shift_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res_n;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.result_kind   = res_q.result_kind;
	assign result.payload_value = res_q.payload_value;
	assign result.payload_index = res_q.payload_index;
	assign result.frame_status  = res_q.frame_status;
	assign result.packet_id     = res_q.packet_id;
	assign result.length_field  = res_q.length_field;

endmodule
